// ----- design/lsf_pkg.sv -----
// shared types and codes for the linear sieve factorizer
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int FACTOR_W = 10;
  localparam int NUMBER_W = 10;
  localparam int LIMIT_W  = 10;
  localparam int STATUS_W = 2;

  // most factors one request can yield
  localparam int MAX_RESULTS = 9;
  localparam int CIDX_W      = $clog2(MAX_RESULTS);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

  typedef logic signed [1:0] mu_t;

  localparam mu_t MU_ZERO = 2'sb00;
  localparam mu_t MU_POS  = 2'sb01;
  localparam mu_t MU_NEG  = 2'sb11;

  localparam logic OP_BUILD  = 1'b0;
  localparam logic OP_FACTOR = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNBUILT = 2'd2;

endpackage

// ----- design/linear_sieve_factorizer_top.sv -----
// linear sieve factorizer: build sequencer, factor walk and result register
//
// Requests enter on start while busy is low. in_operation selects a build
// (tables up to cfg limit) or a factorization of in_number. cfg_we writes
// the limit register (reset 1023); the user must only use cfg_we while the
// block is idle, the block itself does not enforce this. A build first
// clears entries 0..limit, one per cycle, then walks the sieve with one
// shared multiply/compare step under the sequencer, then gives one
// acknowledge result. A build with limit zero is acknowledged without
// clearing or walking and leaves the tables unchanged.
// A factorization reads the table once per emitted factor, through the
// single registered read port, then emits the factors largest first
// on consecutive cycles, the last one marked by out_last. Errors give one
// result from the acknowledge state.
// Each result is shown for one cycle with out_valid; the receiver cannot
// stall. busy stays high until the final result is registered, so a new
// request may be taken in the cycle that result is shown.
// Reset clears the control state; tables read as unbuilt until a build.

`timescale 1ns / 1ps

module linear_sieve_factorizer_top #(
  parameter int MAX_VALUE   = 1024,
  parameter int PRIME_SLOTS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [lsf_pkg::NUMBER_W-1:0]    in_number,
  input  logic                            cfg_we,
  input  logic [lsf_pkg::LIMIT_W-1:0]     cfg_wdata,
  output logic                            out_valid,
  output logic [lsf_pkg::FACTOR_W-1:0]    out_factor,
  output lsf_pkg::mu_t                    out_mobius_value,
  output logic [lsf_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_last
);

  localparam int AW  = $clog2(MAX_VALUE);
  localparam int PW  = 2 * AW;
  localparam int PIW = $clog2(PRIME_SLOTS);
  localparam int PCW = $clog2(PRIME_SLOTS + 1);
  localparam int CW  = (AW > lsf_pkg::LIMIT_W) ? AW : lsf_pkg::LIMIT_W;
  localparam logic [AW-1:0] LIM_MAX = AW'(MAX_VALUE - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_PCHK = 4'd5;
  localparam logic [3:0] S_MARK = 4'd6;
  localparam logic [3:0] S_QRD  = 4'd7;
  localparam logic [3:0] S_QCHK = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;
  localparam logic [3:0] S_ACK  = 4'd10;

  logic [3:0]                         state_r, state_nxt;
  logic [lsf_pkg::LIMIT_W-1:0]        limit_r, limit_nxt;
  logic                               built_r, built_nxt;
  logic [AW-1:0]                      built_lim_r, built_lim_nxt;
  logic [AW-1:0]                      lim_r, lim_nxt;
  logic [AW-1:0]                      clr_r, clr_nxt;
  logic [AW-1:0]                      i_r, i_nxt;
  logic [PCW-1:0]                     count_r, count_nxt;
  logic [PCW-1:0]                     k_r, k_nxt;
  logic [AW-1:0]                      cur_spf_r, cur_spf_nxt;
  lsf_pkg::mu_t                       cur_mu_r, cur_mu_nxt;
  logic [AW-1:0]                      p_r, p_nxt;
  logic [PW-1:0]                      prod_r, prod_nxt;
  logic [AW-1:0]                      m_r, m_nxt;
  lsf_pkg::mu_t                       mu_q_r, mu_q_nxt;
  logic [lsf_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [lsf_pkg::CIDX_W-1:0]         ptr_r, ptr_nxt;
  logic [lsf_pkg::STATUS_W-1:0]       ack_status_r, ack_status_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [lsf_pkg::FACTOR_W-1:0]       out_factor_r, out_factor_nxt;
  lsf_pkg::mu_t                       out_mu_r, out_mu_nxt;
  logic [lsf_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic                               out_last_r, out_last_nxt;

  logic [lsf_pkg::FACTOR_W-1:0]       chain_r [lsf_pkg::MAX_RESULTS];
  logic                               chain_we;
  logic [lsf_pkg::CIDX_W-1:0]         chain_idx;
  logic [lsf_pkg::FACTOR_W-1:0]       chain_wdata;

  logic                               tbl_we, tbl_re;
  logic [AW-1:0]                      tbl_waddr, tbl_wspf, tbl_wcof, tbl_raddr;
  lsf_pkg::mu_t                       tbl_wmu;
  logic [AW-1:0]                      tbl_rspf, tbl_rcof;
  lsf_pkg::mu_t                       tbl_rmu;

  logic                               pl_we, pl_re;
  logic [PIW-1:0]                     pl_waddr, pl_raddr;
  logic [AW-1:0]                      pl_wdata, pl_rdata;

  logic                               accept;
  logic                               adv_i;
  logic                               finish;
  logic [AW-1:0]                      lim_eff;
  logic                               num_bad;

  lsf_table #(
    .DEPTH (MAX_VALUE),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wspf  (tbl_wspf),
    .wcof  (tbl_wcof),
    .wmu   (tbl_wmu),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rspf  (tbl_rspf),
    .rcof  (tbl_rcof),
    .rmu   (tbl_rmu)
  );

  lsf_plist #(
    .DEPTH (PRIME_SLOTS),
    .IW    (PIW),
    .DW    (AW)
  ) u_plist (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .re    (pl_re),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  assign accept = start && !busy;

  assign lim_eff = (CW'(limit_r) > CW'(LIM_MAX)) ? LIM_MAX : AW'(limit_r);
  assign num_bad = (in_number == '0) || (CW'(in_number) > CW'(built_lim_r));

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    built_nxt      = built_r;
    built_lim_nxt  = built_lim_r;
    lim_nxt        = lim_r;
    clr_nxt        = clr_r;
    i_nxt          = i_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    cur_spf_nxt    = cur_spf_r;
    cur_mu_nxt     = cur_mu_r;
    p_nxt          = p_r;
    prod_nxt       = prod_r;
    m_nxt          = m_r;
    mu_q_nxt       = mu_q_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    ack_status_nxt = ack_status_r;

    out_valid_nxt  = 1'b0;
    out_factor_nxt = out_factor_r;
    out_mu_nxt     = out_mu_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    chain_we    = 1'b0;
    chain_idx   = cnt_r[lsf_pkg::CIDX_W-1:0];
    chain_wdata = lsf_pkg::FACTOR_W'(tbl_rspf);

    tbl_we    = 1'b0;
    tbl_waddr = clr_r;
    tbl_wspf  = '0;
    tbl_wcof  = '0;
    tbl_wmu   = lsf_pkg::MU_ZERO;
    tbl_re    = 1'b0;
    tbl_raddr = i_r;

    pl_we    = 1'b0;
    pl_waddr = count_r[PIW-1:0];
    pl_wdata = i_r;
    pl_re    = 1'b0;
    pl_raddr = k_r[PIW-1:0];

    adv_i  = 1'b0;
    finish = 1'b0;

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == lsf_pkg::OP_BUILD) begin
            if (limit_r == '0) begin
              ack_status_nxt = lsf_pkg::ST_OK;
              state_nxt      = S_ACK;
            end else begin
              lim_nxt   = lim_eff;
              clr_nxt   = '0;
              count_nxt = '0;
              state_nxt = S_CLR;
            end
          end else if (!built_r) begin
            ack_status_nxt = lsf_pkg::ST_UNBUILT;
            state_nxt      = S_ACK;
          end else if (num_bad) begin
            ack_status_nxt = lsf_pkg::ST_RANGE;
            state_nxt      = S_ACK;
          end else begin
            tbl_re    = 1'b1;
            tbl_raddr = AW'(in_number);
            m_nxt     = AW'(in_number);
            cnt_nxt   = '0;
            state_nxt = S_QCHK;
          end
        end
      end

      S_CLR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        // entry one is seeded as a unit
        if (clr_r == AW'(1)) begin
          tbl_wspf = AW'(1);
          tbl_wcof = AW'(1);
          tbl_wmu  = lsf_pkg::MU_POS;
        end
        if (clr_r == lim_r) begin
          i_nxt = AW'(2);
          if (lim_r < AW'(2)) begin
            finish = 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      S_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = i_r;
        state_nxt = S_CHK;
      end

      S_CHK: begin
        cur_spf_nxt = tbl_rspf;
        cur_mu_nxt  = tbl_rmu;
        k_nxt       = '0;
        state_nxt   = S_PRD;
        // unmarked entry is a new prime
        if (tbl_rspf == '0) begin
          tbl_we      = 1'b1;
          tbl_waddr   = i_r;
          tbl_wspf    = i_r;
          tbl_wcof    = AW'(1);
          tbl_wmu     = lsf_pkg::MU_NEG;
          cur_spf_nxt = i_r;
          cur_mu_nxt  = lsf_pkg::MU_NEG;
          if (count_r < PCW'(PRIME_SLOTS)) begin
            pl_we     = 1'b1;
            count_nxt = count_r + PCW'(1);
          end
        end
      end

      S_PRD: begin
        if (k_r < count_r) begin
          pl_re     = 1'b1;
          state_nxt = S_PCHK;
        end else begin
          adv_i = 1'b1;
        end
      end

      S_PCHK: begin
        p_nxt     = pl_rdata;
        prod_nxt  = PW'(i_r) * PW'(pl_rdata);
        state_nxt = S_MARK;
      end

      S_MARK: begin
        if ((p_r > cur_spf_r) || (prod_r > PW'(lim_r))) begin
          adv_i = 1'b1;
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = prod_r[AW-1:0];
          tbl_wspf  = p_r;
          tbl_wcof  = i_r;
          // p equal to the smallest factor of i means p divides i
          if (p_r == cur_spf_r) begin
            tbl_wmu = lsf_pkg::MU_ZERO;
            adv_i   = 1'b1;
          end else begin
            tbl_wmu   = -cur_mu_r;
            k_nxt     = k_r + PCW'(1);
            state_nxt = S_PRD;
          end
        end
      end

      S_QRD: begin
        tbl_re    = 1'b1;
        tbl_raddr = m_r;
        state_nxt = S_QCHK;
      end

      S_QCHK: begin
        if (cnt_r == '0) begin
          mu_q_nxt = tbl_rmu;
        end
        if (cnt_r < lsf_pkg::CNT_W'(lsf_pkg::MAX_RESULTS)) begin
          chain_we = 1'b1;
          cnt_nxt  = cnt_r + lsf_pkg::CNT_W'(1);
        end
        if ((tbl_rspf == '0) || (tbl_rspf == m_r) ||
            (cnt_r == lsf_pkg::CNT_W'(lsf_pkg::MAX_RESULTS - 1))) begin
          ptr_nxt   = cnt_r[lsf_pkg::CIDX_W-1:0];
          state_nxt = S_EMIT;
        end else begin
          m_nxt     = tbl_rcof;
          state_nxt = S_QRD;
        end
      end

      S_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_factor_nxt = chain_r[ptr_r];
        out_mu_nxt     = mu_q_r;
        out_status_nxt = lsf_pkg::ST_OK;
        out_last_nxt   = (ptr_r == '0);
        if (ptr_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r - lsf_pkg::CIDX_W'(1);
        end
      end

      S_ACK: begin
        out_valid_nxt  = 1'b1;
        out_factor_nxt = '0;
        out_mu_nxt     = lsf_pkg::MU_ZERO;
        out_status_nxt = ack_status_r;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // next sieve row, or wrap up the build
    if (adv_i) begin
      if (i_r == lim_r) begin
        finish = 1'b1;
      end else begin
        i_nxt     = i_r + AW'(1);
        state_nxt = S_RD;
      end
    end

    if (finish) begin
      built_nxt      = 1'b1;
      built_lim_nxt  = lim_r;
      ack_status_nxt = lsf_pkg::ST_OK;
      state_nxt      = S_ACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= lsf_pkg::LIMIT_RESET;
      built_r     <= 1'b0;
      built_lim_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      built_r     <= built_nxt;
      built_lim_r <= built_lim_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r        <= lim_nxt;
    clr_r        <= clr_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    cur_spf_r    <= cur_spf_nxt;
    cur_mu_r     <= cur_mu_nxt;
    p_r          <= p_nxt;
    prod_r       <= prod_nxt;
    m_r          <= m_nxt;
    mu_q_r       <= mu_q_nxt;
    cnt_r        <= cnt_nxt;
    ptr_r        <= ptr_nxt;
    ack_status_r <= ack_status_nxt;
    out_factor_r <= out_factor_nxt;
    out_mu_r     <= out_mu_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    if (chain_we) begin
      chain_r[chain_idx] <= chain_wdata;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_factor       = out_factor_r;
  assign out_mobius_value = out_mu_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

// ----- design/lsf_table.sv -----
// smallest factor, cofactor and mobius table, one write and one registered read port
`timescale 1ns / 1ps

module lsf_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  logic [AW-1:0]  wspf,
  input  logic [AW-1:0]  wcof,
  input  lsf_pkg::mu_t   wmu,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output logic [AW-1:0]  rspf,
  output logic [AW-1:0]  rcof,
  output lsf_pkg::mu_t   rmu
);

  localparam int WW = 2 * AW + 2;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wspf, wcof, wmu};
    end
    if (re) begin
      rd_word_r <= mem[raddr];
    end
  end

  assign rspf = rd_word_r[WW-1 -: AW];
  assign rcof = rd_word_r[AW+1 -: AW];
  assign rmu  = rd_word_r[1:0];

endmodule

// ----- design/lsf_plist.sv -----
// prime list memory, one write and one registered read port
`timescale 1ns / 1ps

module lsf_plist #(
  parameter int DEPTH = 256,
  parameter int IW    = 8,
  parameter int DW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lsf_checker.sv -----
// port-level checks for the linear sieve factorizer, bound to the top level
`timescale 1ns / 1ps

module lsf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [lsf_pkg::FACTOR_W-1:0]  out_factor,
  input lsf_pkg::mu_t                  out_mobius_value,
  input logic [lsf_pkg::STATUS_W-1:0]  out_status,
  input logic                          out_last
);

  // a taken request always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // error results are single and empty
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lsf_pkg::ST_OK) |->
      out_last && (out_factor == '0) && (out_mobius_value == lsf_pkg::MU_ZERO))
    else $error("error result not a lone empty result");

  // factors run back to back, nonincreasing, with one mobius value
  a_factor_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=>
      out_valid && (out_mobius_value == $past(out_mobius_value)) &&
      (out_factor <= $past(out_factor)))
    else $error("factor run broken or out of order");

  // going idle always coincides with a final result
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_last)
    else $error("block went idle without a final result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind linear_sieve_factorizer_top lsf_checker u_lsf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_factor       (out_factor),
  .out_mobius_value (out_mobius_value),
  .out_status       (out_status),
  .out_last         (out_last)
);

// ----- verif/tb_linear_sieve_factorizer_top.sv -----
// self-checking testbench for the linear sieve factorizer top level
`timescale 1ns / 1ps

module tb_linear_sieve_factorizer_top;

  localparam int IDLE_LIMIT        = 50000;
  localparam int SETTLE_CYCLES     = 20;
  localparam int RANDOM_PHASES     = 10;
  localparam int QUERIES_PER_PHASE = 13;
  localparam int TABLE_SIZE        = 1024;
  localparam int PRIME_ROOM        = 256;
  localparam int REPORT_CAP        = 20;

  typedef struct packed {
    logic [lsf_pkg::FACTOR_W-1:0] factor;
    lsf_pkg::mu_t                 mobius;
    logic [lsf_pkg::STATUS_W-1:0] status;
    logic                         last;
  } factor_result_t;

  class sieve_scoreboard;
    logic [lsf_pkg::FACTOR_W-1:0] spf_table [TABLE_SIZE];
    lsf_pkg::mu_t                 mobius_table [TABLE_SIZE];
    logic [lsf_pkg::FACTOR_W-1:0] prime_list [PRIME_ROOM];
    int unsigned                  prime_count;
    bit                           tables_ready;
    logic [lsf_pkg::LIMIT_W-1:0]  limit_reg;
    int unsigned                  built_limit;
    factor_result_t               pending [$];
    int unsigned                  n_errors;
    int unsigned                  n_results;
    int unsigned                  n_builds;
    int unsigned                  n_queries;

    function new();
      for (int i = 0; i < TABLE_SIZE; i++) begin
        spf_table[i] = '0;
        mobius_table[i] = lsf_pkg::MU_ZERO;
      end
      prime_count = 0;
      tables_ready = 1'b0;
      limit_reg = lsf_pkg::LIMIT_RESET;
      built_limit = 0;
      n_errors = 0;
      n_results = 0;
      n_builds = 0;
      n_queries = 0;
    endfunction

    task report(string what);
      if (n_errors < REPORT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      n_errors++;
    endtask

    function void run_sieve();
      int unsigned lim;
      int unsigned p;
      if (limit_reg == 0) return;
      lim = limit_reg;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        spf_table[i] = '0;
        mobius_table[i] = lsf_pkg::MU_ZERO;
      end
      prime_count = 0;
      spf_table[1] = lsf_pkg::FACTOR_W'(1);
      mobius_table[1] = lsf_pkg::MU_POS;
      for (int unsigned i = 2; i <= lim; i++) begin
        if (spf_table[i] == 0) begin
          spf_table[i] = lsf_pkg::FACTOR_W'(i);
          mobius_table[i] = lsf_pkg::MU_NEG;
          if (prime_count < PRIME_ROOM) begin
            prime_list[prime_count] = lsf_pkg::FACTOR_W'(i);
            prime_count++;
          end
        end
        for (int unsigned k = 0; k < prime_count; k++) begin
          p = prime_list[k];
          if (p > spf_table[i] || i * p > lim) break;
          spf_table[i * p] = lsf_pkg::FACTOR_W'(p);
          // a repeated prime kills the mobius value and ends the walk
          if (i % p == 0) begin
            mobius_table[i * p] = lsf_pkg::MU_ZERO;
            break;
          end
          mobius_table[i * p] = -mobius_table[i];
        end
      end
      tables_ready = 1'b1;
      built_limit = lim;
    endfunction

    function void push_single(logic [lsf_pkg::STATUS_W-1:0] st);
      factor_result_t r;
      r.factor = '0;
      r.mobius = lsf_pkg::MU_ZERO;
      r.status = st;
      r.last = 1'b1;
      pending = {pending, r};
    endfunction

    function void note_request(logic op, logic [lsf_pkg::NUMBER_W-1:0] num);
      logic [lsf_pkg::FACTOR_W-1:0] chain [$];
      factor_result_t r;
      int unsigned m;
      int unsigned total;
      if (op == lsf_pkg::OP_BUILD) begin
        n_builds++;
        run_sieve();
        push_single(lsf_pkg::ST_OK);
        return;
      end
      n_queries++;
      if (!tables_ready) begin
        push_single(lsf_pkg::ST_UNBUILT);
        return;
      end
      if (num == 0 || spf_table[num] == 0) begin
        push_single(lsf_pkg::ST_RANGE);
        return;
      end
      m = num;
      while (spf_table[m] != 0 && spf_table[m] != m) begin
        chain = {chain, spf_table[m]};
        m = m / spf_table[m];
      end
      chain = {chain, spf_table[m]};
      total = (chain.size() > lsf_pkg::MAX_RESULTS) ? lsf_pkg::MAX_RESULTS : chain.size();
      // smallest factor comes out of the table first, so emit in reverse
      for (int unsigned k = 0; k < total; k++) begin
        r.factor = chain[chain.size() - 1 - k];
        r.mobius = mobius_table[num];
        r.status = lsf_pkg::ST_OK;
        r.last = (k == total - 1);
        pending = {pending, r};
      end
    endfunction

    task check_result(logic [lsf_pkg::FACTOR_W-1:0] factor, lsf_pkg::mu_t mobius,
                      logic [lsf_pkg::STATUS_W-1:0] status, logic last);
      factor_result_t want;
      n_results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result factor %0d status %0d", factor, status));
        return;
      end
      want = pending.pop_front();
      if (factor !== want.factor)
        report($sformatf("factor %0d, want %0d", factor, want.factor));
      if (mobius !== want.mobius)
        report($sformatf("mobius %0d, want %0d", $signed(mobius), $signed(want.mobius)));
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (last !== want.last)
        report($sformatf("last %0b, want %0b", last, want.last));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_operation;
  logic [lsf_pkg::NUMBER_W-1:0] in_number;
  logic                         cfg_we;
  logic [lsf_pkg::LIMIT_W-1:0]  cfg_wdata;
  logic                         out_valid;
  logic [lsf_pkg::FACTOR_W-1:0] out_factor;
  lsf_pkg::mu_t                 out_mobius_value;
  logic [lsf_pkg::STATUS_W-1:0] out_status;
  logic                         out_last;

  sieve_scoreboard sb;
  int unsigned     idle_cycles = 0;
  int unsigned     lowest_limit = lsf_pkg::LIMIT_RESET;
  int unsigned     highest_limit = 0;

  wire request_taken = start && !busy;

  always #2 clk = ~clk;

  linear_sieve_factorizer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_number        (in_number),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_factor       (out_factor),
    .out_mobius_value (out_mobius_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_factor, out_mobius_value, out_status, out_last);
  end

  // a full build stays quiet until its acknowledge, and the limit is set well above its length
  always @(posedge clk) begin
    if (!rst_n || request_taken || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("tb_linear_sieve_factorizer_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic op, logic [lsf_pkg::NUMBER_W-1:0] num);
    start <= 1'b1;
    in_operation <= op;
    in_number <= num;
    do @(posedge clk); while (busy);
    sb.note_request(op, num);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [lsf_pkg::LIMIT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit_reg = value;
    if (value < lowest_limit) lowest_limit = value;
    if (value > highest_limit) highest_limit = value;
  endtask

  function automatic logic [lsf_pkg::NUMBER_W-1:0] pick_number();
    int unsigned lim;
    int unsigned sel;
    int unsigned pow;
    lim = sb.built_limit;
    sel = $urandom_range(0, 99);
    if (lim == 0 || (sel >= 55 && sel < 75)) return lsf_pkg::NUMBER_W'($urandom);
    if (sel < 55) return lsf_pkg::NUMBER_W'($urandom_range(1, lim));
    if (sel < 85) return lsf_pkg::NUMBER_W'($urandom_range(0, 1));
    if (sel < 92) begin
      return (lim < 1023) ? lsf_pkg::NUMBER_W'($urandom_range(lim + 1, 1023)) : 10'd1023;
    end
    // powers of two give the longest factor lists
    pow = 1 << $urandom_range(0, 9);
    return lsf_pkg::NUMBER_W'((pow <= lim) ? pow : lim);
  endfunction

  initial begin
    int unsigned burst_left;
    logic [lsf_pkg::LIMIT_W-1:0] next_limit;
    sb = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= lsf_pkg::OP_BUILD;
    in_number <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // queries before anything is built
    send_request(lsf_pkg::OP_FACTOR, 10'd0);
    send_request(lsf_pkg::OP_FACTOR, 10'd1023);
    wait_for_drain();
    // zero limit: acknowledged but tables stay unbuilt
    write_limit(10'd0);
    send_request(lsf_pkg::OP_BUILD, 10'd1023);
    send_request(lsf_pkg::OP_FACTOR, 10'd5);
    wait_for_drain();

    write_limit(10'd1023);
    send_request(lsf_pkg::OP_BUILD, 10'd0);
    send_request(lsf_pkg::OP_FACTOR, 10'd0);
    send_request(lsf_pkg::OP_FACTOR, 10'd1);
    send_request(lsf_pkg::OP_FACTOR, 10'd2);
    send_request(lsf_pkg::OP_FACTOR, 10'd512);
    send_request(lsf_pkg::OP_FACTOR, 10'd1023);
    send_request(lsf_pkg::OP_FACTOR, 10'd1022);
    send_request(lsf_pkg::OP_FACTOR, 10'd997);
    send_request(lsf_pkg::OP_FACTOR, 10'd30);
    send_request(lsf_pkg::OP_FACTOR, 10'd6);
    send_request(lsf_pkg::OP_FACTOR, 10'd12);
    wait_for_drain();

    // shrinking the table must hide entries from the earlier larger build
    write_limit(10'd50);
    send_request(lsf_pkg::OP_BUILD, 10'd777);
    send_request(lsf_pkg::OP_FACTOR, 10'd100);
    send_request(lsf_pkg::OP_FACTOR, 10'd50);
    send_request(lsf_pkg::OP_FACTOR, 10'd49);
    send_request(lsf_pkg::OP_FACTOR, 10'd51);
    wait_for_drain();

    write_limit(10'd1);
    send_request(lsf_pkg::OP_BUILD, 10'd0);
    send_request(lsf_pkg::OP_FACTOR, 10'd1);
    send_request(lsf_pkg::OP_FACTOR, 10'd2);
    wait_for_drain();
    write_limit(10'd0);
    send_request(lsf_pkg::OP_BUILD, 10'd0);
    send_request(lsf_pkg::OP_FACTOR, 10'd1);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_drain();
      if ($urandom_range(0, 9) == 0) next_limit = lsf_pkg::LIMIT_W'($urandom_range(0, 1));
      else if (phase % 5 == 4) next_limit = lsf_pkg::LIMIT_W'($urandom_range(512, 1023));
      else next_limit = lsf_pkg::LIMIT_W'($urandom_range(2, 128));
      write_limit(next_limit);
      send_request(lsf_pkg::OP_BUILD, lsf_pkg::NUMBER_W'($urandom));
      burst_left = $urandom_range(1, 12);
      for (int q = 0; q < QUERIES_PER_PHASE; q++) begin
        // an occasional rebuild in the middle of a query stream, only where it is cheap
        if (sb.limit_reg < 200 && $urandom_range(0, 19) == 0)
          send_request(lsf_pkg::OP_BUILD, lsf_pkg::NUMBER_W'($urandom));
        else
          send_request(lsf_pkg::OP_FACTOR, pick_number());
        burst_left--;
        if (burst_left == 0) begin
          pause_sender($urandom_range(1, 8));
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d builds and %0d factor requests, %0d results checked",
             sb.n_builds, sb.n_queries, sb.n_results);
    $display("sieve limits written ranged from %0d to %0d", lowest_limit, highest_limit);
    if (sb.n_errors == 0) begin
      $display("tb_linear_sieve_factorizer_top: clean");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("tb_linear_sieve_factorizer_top: errors");
    end
    $finish;
  end

endmodule
